// ----- rtl/sfce_pkg.sv -----
// ----------------------------------------------------------------------------
// sfce_pkg: shared types and constants of the SPI flash command engine
// Command codes, phases, operation kinds and the item payload structs.
// ----------------------------------------------------------------------------
package sfce_pkg;

  localparam logic [7:0] CMD_WRITE_ENABLE = 8'h06;
  localparam logic [7:0] CMD_READ_STATUS  = 8'h05;
  localparam logic [7:0] CMD_PAGE_PROGRAM = 8'h02;
  localparam logic [7:0] CMD_FAST_READ    = 8'h0B;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_DATA    = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_PROGRAM = 3'd3;
  localparam logic [2:0] OP_ERASE   = 3'd4;

  localparam logic [2:0] REG_ERASE_OPCODE  = 3'd0;
  localparam logic [2:0] REG_ZERO_COUNT    = 3'd1;
  localparam logic [2:0] REG_ZERO_SIZES    = 3'd2;
  localparam logic [2:0] REG_PROGRAM_LIMIT = 3'd3;
  localparam logic [2:0] REG_ERASE_LIMIT   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WREN, PH_GAP_WREN, PH_CMD, PH_RDATA, PH_WDATA,
    PH_GAP_CMD, PH_POLL_CMD, PH_POLL_RX, PH_GAP_POLL
  } phase_t;

  typedef enum logic [1:0] {KIND_READ, KIND_PROGRAM, KIND_ERASE} kind_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [23:0] address;
    logic [23:0] length;
    logic [7:0]  data_byte;
    logic        miso;
  } in_item_t;

  typedef struct packed {
    logic       chip_select_active;
    logic       mosi;
    logic       clock_pulse;
    logic [7:0] read_data;
    logic       read_valid;
    logic       data_wanted;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  erase_opcode;
    logic [3:0]  zero_sector_count;
    logic [63:0] zero_sector_sizes;
    logic [31:0] program_poll_limit;
    logic [31:0] erase_poll_limit;
  } cfg_t;

endpackage

// ----- rtl/sfce_in_if.sv -----
// ----------------------------------------------------------------------------
// sfce_in_if: input item channel
// Valid/ready channel carrying one command, data or tick item.
// ----------------------------------------------------------------------------
interface sfce_in_if;
  logic              valid;
  logic              ready;
  sfce_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/sfce_out_if.sv -----
// ----------------------------------------------------------------------------
// sfce_out_if: result item channel
// Valid/ready channel carrying one pin and status result item.
// ----------------------------------------------------------------------------
interface sfce_out_if;
  logic               valid;
  logic               ready;
  sfce_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/sfce_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sfce_cfg_regs: configuration register file
// Holds the erase opcode, zero-region sector table and poll budgets.
// ----------------------------------------------------------------------------
module sfce_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  output sfce_pkg::cfg_t       cfg
);
  sfce_pkg::cfg_t cfg_r;

  // write one register per enabled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.erase_opcode       <= 8'h20;
      cfg_r.zero_sector_count  <= 4'd1;
      cfg_r.zero_sector_sizes  <= '0;
      cfg_r.program_poll_limit <= 32'd100000;
      cfg_r.erase_poll_limit   <= 32'd10000000;
    end else if (cfg_we) begin
      case (cfg_index)
        sfce_pkg::REG_ERASE_OPCODE:  cfg_r.erase_opcode       <= cfg_data[7:0];
        sfce_pkg::REG_ZERO_COUNT:    cfg_r.zero_sector_count  <= cfg_data[3:0];
        sfce_pkg::REG_ZERO_SIZES:    cfg_r.zero_sector_sizes  <= cfg_data;
        sfce_pkg::REG_PROGRAM_LIMIT: cfg_r.program_poll_limit <= cfg_data[31:0];
        sfce_pkg::REG_ERASE_LIMIT:   cfg_r.erase_poll_limit   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

// ----- rtl/sfce_core.sv -----
// ----------------------------------------------------------------------------
// sfce_core: command sequencer
// Steps the SPI frame state by one item and forms that item's result.
// ----------------------------------------------------------------------------
module sfce_core #(
  parameter int PAGE_BYTES       = 256,
  parameter int ADDRESS_BITS     = 24,
  parameter int ZERO_SECTORS_MAX = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  sfce_pkg::in_item_t  item,
  input  sfce_pkg::cfg_t      cfg,
  output sfce_pkg::out_item_t res
);
  localparam int FBW = $clog2(PAGE_BYTES + 1);
  localparam logic [23:0] AMASK = 24'((33'd1 << ADDRESS_BITS) - 33'd1);

  sfce_pkg::phase_t phase_r, phase_nxt;
  sfce_pkg::kind_t  kind_r, kind_nxt;
  logic [7:0]  tx_r, tx_nxt, rx_r, rx_nxt, held_r, held_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [FBW-1:0] fbc_r, fbc_nxt;
  logic [23:0] addr_r, addr_nxt, left_r, left_nxt;
  logic        hv_r, hv_nxt, err_r, err_nxt, cs_r, cs_nxt, mo_r, mo_nxt;
  logic [31:0] poll_r, poll_nxt;
  logic [3:0]  sidx_r, sidx_nxt, stot_r, stot_nxt;

  // combinational helpers
  logic [7:0]  hdr, fresh, txs;
  logic [31:0] limit;
  logic        timed;
  logic [7:0]  units;
  logic        do_send, do_recv;
  logic [23:0] left_dec;

  always_comb begin
    case (fbc_r)
      FBW'(0): begin
        case (kind_r)
          sfce_pkg::KIND_READ:    hdr = sfce_pkg::CMD_FAST_READ;
          sfce_pkg::KIND_PROGRAM: hdr = sfce_pkg::CMD_PAGE_PROGRAM;
          default:                hdr = cfg.erase_opcode;
        endcase
      end
      FBW'(1): hdr = addr_r[23:16] & AMASK[23:16];
      FBW'(2): hdr = addr_r[15:8];
      FBW'(3): hdr = addr_r[7:0];
      default: hdr = 8'h00;
    endcase
    limit = (kind_r == sfce_pkg::KIND_PROGRAM) ? cfg.program_poll_limit
                                               : cfg.erase_poll_limit;
    units = cfg.zero_sector_sizes[{sidx_r[2:0], 3'b000} +: 8];
  end

  // next state and result of one item
  always_comb begin
    phase_nxt = phase_r; kind_nxt = kind_r; tx_nxt = tx_r; rx_nxt = rx_r;
    held_nxt = held_r; bit_nxt = bit_r; fbc_nxt = fbc_r; addr_nxt = addr_r;
    left_nxt = left_r; hv_nxt = hv_r; err_nxt = err_r; poll_nxt = poll_r;
    sidx_nxt = sidx_r; stot_nxt = stot_r; cs_nxt = cs_r; mo_nxt = mo_r;
    fresh = 8'h00; txs = 8'h00; timed = 1'b0; do_send = 1'b0; do_recv = 1'b0;
    left_dec = (left_r != 24'd0) ? left_r - 24'd1 : left_r;
    res = '0;
    res.chip_select_active = cs_r;
    res.mosi = mo_r;

    if (item.op == sfce_pkg::OP_TICK) begin
      res.chip_select_active = 1'b0;
      res.mosi = 1'b0;
      if ((phase_r == sfce_pkg::PH_POLL_CMD || phase_r == sfce_pkg::PH_POLL_RX ||
           phase_r == sfce_pkg::PH_GAP_POLL) && poll_r != 32'hFFFF_FFFF)
        poll_nxt = poll_r + 32'd1;
      case (phase_r)
        sfce_pkg::PH_WREN: begin
          do_send = 1'b1; fresh = sfce_pkg::CMD_WRITE_ENABLE;
          if (bit_r == 3'd7) phase_nxt = sfce_pkg::PH_GAP_WREN;
        end
        sfce_pkg::PH_GAP_WREN: begin
          fbc_nxt = '0;
          phase_nxt = sfce_pkg::PH_CMD;
        end
        sfce_pkg::PH_CMD: begin
          do_send = 1'b1; fresh = hdr;
          if (bit_r == 3'd7) begin
            fbc_nxt = fbc_r + FBW'(1);
            if (fbc_r + FBW'(1) >= ((kind_r == sfce_pkg::KIND_READ) ? FBW'(5) : FBW'(4)))
            begin
              fbc_nxt = '0;
              case (kind_r)
                sfce_pkg::KIND_READ:    phase_nxt = sfce_pkg::PH_RDATA;
                sfce_pkg::KIND_PROGRAM: phase_nxt = sfce_pkg::PH_WDATA;
                default:                phase_nxt = sfce_pkg::PH_GAP_CMD;
              endcase
            end
          end
        end
        sfce_pkg::PH_RDATA: begin
          do_recv = 1'b1;
          if (bit_r == 3'd7) begin
            res.read_valid = 1'b1;
            res.read_data = {rx_r[6:0], item.miso};
            left_nxt = left_dec;
            if (left_dec == 24'd0) phase_nxt = sfce_pkg::PH_GAP_CMD;
          end
        end
        sfce_pkg::PH_WDATA: begin
          if (bit_r == 3'd0 && !hv_r) begin
            res.chip_select_active = 1'b1;
            if (left_r == 24'd0) phase_nxt = sfce_pkg::PH_GAP_CMD;
          end else begin
            if (bit_r == 3'd0) begin
              hv_nxt = 1'b0;
              left_nxt = left_dec;
            end
            do_send = 1'b1; fresh = held_r;
            if (bit_r == 3'd7) begin
              fbc_nxt = fbc_r + FBW'(1);
              if (left_r == 24'd0 || fbc_r + FBW'(1) >= FBW'(PAGE_BYTES))
                phase_nxt = sfce_pkg::PH_GAP_CMD;
            end
          end
        end
        sfce_pkg::PH_GAP_CMD: begin
          if (kind_r == sfce_pkg::KIND_READ) begin
            phase_nxt = sfce_pkg::PH_IDLE; res.done_res = 1'b1;
            res.status = sfce_pkg::ST_OK;
            hv_nxt = 1'b0; bit_nxt = '0; fbc_nxt = '0;
          end else begin
            poll_nxt = '0;
            phase_nxt = sfce_pkg::PH_POLL_CMD;
          end
        end
        sfce_pkg::PH_POLL_CMD: begin
          do_send = 1'b1; fresh = sfce_pkg::CMD_READ_STATUS;
          if (bit_r == 3'd7) phase_nxt = sfce_pkg::PH_POLL_RX;
        end
        sfce_pkg::PH_POLL_RX: begin
          do_recv = 1'b1;
          if (bit_r == 3'd7) phase_nxt = sfce_pkg::PH_GAP_POLL;
        end
        sfce_pkg::PH_GAP_POLL: begin
          timed = poll_nxt >= limit;
          if (!timed && rx_r[0]) begin
            phase_nxt = sfce_pkg::PH_POLL_CMD;
          end else if (kind_r == sfce_pkg::KIND_PROGRAM) begin
            if (timed || left_r == 24'd0) begin
              phase_nxt = sfce_pkg::PH_IDLE; res.done_res = 1'b1;
              res.status = timed ? sfce_pkg::ST_TIMEOUT : sfce_pkg::ST_OK;
              hv_nxt = 1'b0; bit_nxt = '0; fbc_nxt = '0;
            end else begin
              addr_nxt = (addr_r + 24'(PAGE_BYTES)) & AMASK;
              fbc_nxt = '0;
              phase_nxt = sfce_pkg::PH_WREN;
            end
          end else begin
            err_nxt = err_r | timed;
            addr_nxt = (addr_r + {4'd0, units, 12'd0}) & AMASK;
            sidx_nxt = sidx_r + 4'd1;
            if (sidx_r + 4'd1 < stot_r) begin
              phase_nxt = sfce_pkg::PH_WREN;
            end else begin
              phase_nxt = sfce_pkg::PH_IDLE; res.done_res = 1'b1;
              res.status = (err_r | timed) ? sfce_pkg::ST_TIMEOUT : sfce_pkg::ST_OK;
              hv_nxt = 1'b0; bit_nxt = '0; fbc_nxt = '0;
            end
          end
        end
        default: phase_nxt = sfce_pkg::PH_IDLE;
      endcase
      // shared shift engine
      if (do_send) begin
        txs = (bit_r == 3'd0) ? fresh : tx_r;
        res.chip_select_active = 1'b1;
        res.mosi = txs[7];
        res.clock_pulse = 1'b1;
        tx_nxt = {txs[6:0], 1'b0};
        bit_nxt = bit_r + 3'd1;
      end
      if (do_recv) begin
        res.chip_select_active = 1'b1;
        res.clock_pulse = 1'b1;
        rx_nxt = {rx_r[6:0], item.miso};
        bit_nxt = bit_r + 3'd1;
      end
      // a finishing tick clears the bit count even after a send
      if (res.done_res) bit_nxt = '0;
      cs_nxt = res.chip_select_active;
      mo_nxt = res.mosi;
    end else if (item.op == sfce_pkg::OP_DATA) begin
      if (phase_r != sfce_pkg::PH_IDLE && kind_r == sfce_pkg::KIND_PROGRAM &&
          !hv_r && left_r != 24'd0) begin
        held_nxt = item.data_byte;
        hv_nxt = 1'b1;
      end
    end else if (item.op == sfce_pkg::OP_READ || item.op == sfce_pkg::OP_PROGRAM ||
                 item.op == sfce_pkg::OP_ERASE) begin
      if (phase_r == sfce_pkg::PH_IDLE) begin
        if (item.op != sfce_pkg::OP_ERASE && item.length == 24'd0) begin
          res.done_res = 1'b1;
          res.status = sfce_pkg::ST_REJECTED;
        end else begin
          addr_nxt = item.address & AMASK;
          bit_nxt = '0; fbc_nxt = '0; hv_nxt = 1'b0; poll_nxt = '0;
          if (item.op == sfce_pkg::OP_READ) begin
            kind_nxt = sfce_pkg::KIND_READ; left_nxt = item.length;
            phase_nxt = sfce_pkg::PH_CMD;
          end else if (item.op == sfce_pkg::OP_PROGRAM) begin
            kind_nxt = sfce_pkg::KIND_PROGRAM; left_nxt = item.length;
            phase_nxt = sfce_pkg::PH_WREN;
          end else begin
            kind_nxt = sfce_pkg::KIND_ERASE; left_nxt = '0;
            sidx_nxt = '0; err_nxt = 1'b0;
            if ((item.address & AMASK) != 24'd0 || cfg.zero_sector_count == 4'd0)
              stot_nxt = 4'd1;
            else if (cfg.zero_sector_count > 4'(ZERO_SECTORS_MAX))
              stot_nxt = 4'(ZERO_SECTORS_MAX);
            else
              stot_nxt = cfg.zero_sector_count;
            phase_nxt = sfce_pkg::PH_WREN;
          end
        end
      end
    end

    res.busy_res = (phase_nxt != sfce_pkg::PH_IDLE);
    res.data_wanted = (phase_nxt != sfce_pkg::PH_IDLE) &&
                      (kind_nxt == sfce_pkg::KIND_PROGRAM) && !hv_nxt &&
                      (left_nxt != 24'd0);
  end

  // advance the sequencer on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sfce_pkg::PH_IDLE; kind_r <= sfce_pkg::KIND_READ;
      tx_r <= '0; rx_r <= '0; held_r <= '0; bit_r <= '0; fbc_r <= '0;
      addr_r <= '0; left_r <= '0; hv_r <= 1'b0; err_r <= 1'b0;
      poll_r <= '0; sidx_r <= '0; stot_r <= '0; cs_r <= 1'b0; mo_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt; kind_r <= kind_nxt; tx_r <= tx_nxt; rx_r <= rx_nxt;
      held_r <= held_nxt; bit_r <= bit_nxt; fbc_r <= fbc_nxt; addr_r <= addr_nxt;
      left_r <= left_nxt; hv_r <= hv_nxt; err_r <= err_nxt; poll_r <= poll_nxt;
      sidx_r <= sidx_nxt; stot_r <= stot_nxt; cs_r <= cs_nxt; mo_r <= mo_nxt;
    end
  end
endmodule

// ----- rtl/spi_flash_command_engine.sv -----
// ----------------------------------------------------------------------------
// spi_flash_command_engine: SPI NOR flash command sequencer
// Fast read, page program and sector erase with status polling.
// ----------------------------------------------------------------------------
// Each accepted item is one SPI bit period (tick) or a command/data item and
// produces exactly one result item. The input is registered, the sequencer
// step is a single pass of logic, and the result sits in an output
// register: one item per clock is sustained while the result side keeps
// up, and the block stalls only when both the input and output registers
// are full.
module spi_flash_command_engine #(
  parameter int PAGE_BYTES       = 256,
  parameter int ADDRESS_BITS     = 24,
  parameter int ZERO_SECTORS_MAX = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  sfce_in_if.sink     in_ch,
  sfce_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  sfce_pkg::cfg_t      cfg;
  sfce_pkg::in_item_t  in_r;
  logic                in_v_r;
  sfce_pkg::out_item_t res, out_r;
  logic                out_v_r;
  logic                step;

  sfce_cfg_regs u_regs (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .cfg
  );

  // step the held item when the output register is free or drains
  assign step = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || step;

  sfce_core #(
    .PAGE_BYTES(PAGE_BYTES), .ADDRESS_BITS(ADDRESS_BITS),
    .ZERO_SECTORS_MAX(ZERO_SECTORS_MAX)
  ) u_core (
    .clk, .rst_n, .step, .item(in_r), .cfg, .res
  );

  // input and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_v_r <= in_ch.valid;
      if (step) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) in_r <= in_ch.payload;
    if (step) out_r <= res;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.payload = out_r;
endmodule

// ----- rtl/sfce_checker.sv -----
// ----------------------------------------------------------------------------
// sfce_checker: port-level checks of the command engine
// Watches the result channel for consistent status reporting.
// ----------------------------------------------------------------------------
module sfce_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input sfce_pkg::out_item_t out_payload
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // status is only reported with done
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.done_res |-> out_payload.status == sfce_pkg::ST_OK)
    else $error("status without done");

  // read data only with read valid
  a_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.read_valid |-> out_payload.read_data == 8'h00)
    else $error("stray read data");

  // a clock pulse needs chip select
  a_clk_cs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.clock_pulse |-> out_payload.chip_select_active)
    else $error("clock without chip select");
endmodule

bind spi_flash_command_engine sfce_checker u_sfce_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_payload(out_ch.payload)
);
